// ----- hdl/wdr_pkg.sv -----
// Package: shared types and constants of the window difficulty retarget block.
`timescale 1ns / 1ps
package wdr_pkg;
  typedef enum logic [3:0] {
    S_LOAD, S_SORT_RD, S_SORT_WAIT, S_SORT_CMP, S_SORT_WR, S_SEL_RD, S_SEL_WAIT,
    S_SEL_CAP, S_MUL, S_DIV, S_OUT
  } state_t;
  localparam int unsigned TimeW = 64;
  localparam int unsigned WorkW = 128;
  localparam int unsigned NumW  = 192;
  localparam logic [31:0] TargetReset = 32'd120;
  localparam logic [1:0] REG_TARGET = 2'd0;
endpackage

// ----- hdl/wdr_divider.sv -----
// Restoring divider: 192-bit dividend by 64-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module wdr_divider
  import wdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NumW-1:0]   dividend,
  input  logic [TimeW-1:0]  divisor,
  output logic              busy,
  output logic              done,
  output logic [NumW-1:0]   quotient
);
  logic [NumW-1:0]  num;
  logic [TimeW-1:0] rem;
  logic [TimeW-1:0] den;
  logic [7:0]       count;
  logic [TimeW:0]   shifted;
  logic             take;

  assign shifted = {rem, num[NumW-1]};
  assign take    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 8'(NumW - 1);
      end else if (busy) begin
        if (count == 8'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      rem      <= '0;
      den      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      num      <= {num[NumW-2:0], 1'b0};
      rem      <= take ? TimeW'(shifted - {1'b0, den}) : shifted[TimeW-1:0];
      quotient <= {quotient[NumW-2:0], take};
    end
  end
endmodule

// ----- hdl/window_difficulty_retarget.sv -----
// Top level: sample window store, insertion sort, retarget multiply and divide.
`timescale 1ns / 1ps
// Usage:
//   Input channel (valid/ready) takes one sample word per handshake: timestamp,
//   128-bit cumulative work and a last flag. A sample without the last flag is
//   stored when taken. Samples past WINDOW are dropped but still handshaken.
//   The last sample starts the computation: an insertion sort of the
//   timestamps in the window memory (each compare/move passes through read,
//   wait and compare states, each insertion ends in a write state), two reads
//   of the trimmed ends, a 4-step 32x32 multiply and a 192-bit restoring divide.
//   in_ready stays low throughout. The result word then sits in an output
//   register until taken; the block resumes loading only after that.
//   Output channel (valid/ready) carries difficulty and the overflow flag.
//   A stalled receiver simply holds the block in the output state.
//   APB port: register 0 at address 0 is the target block interval in seconds
//   (reset 120).
//   Synchronous reset empties the window and restores the target interval; the
//   memories are not cleared and never read before written.
module window_difficulty_retarget
  import wdr_pkg::*;
#(
  parameter int unsigned WINDOW = 720,
  parameter int unsigned TRIM   = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] sample_time,
  input  logic [63:0] work_low,
  input  logic [63:0] work_high,
  input  logic        last_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] difficulty_low,
  output logic [63:0] difficulty_high,
  output logic        overflowed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int KeptRaw = int'(WINDOW) - 2 * int'(TRIM);
  localparam int Kept = (KeptRaw < 2) ? 2 : KeptRaw;

  logic [TimeW-1:0] tmem [WINDOW];
  logic [WorkW-1:0] wmem [WINDOW];

  state_t state, state_next;
  logic [31:0]      target;
  logic [CW-1:0]    count, len;
  logic [CW-1:0]    i_idx, j_idx;
  logic [TimeW-1:0] key, tq;
  logic [WorkW-1:0] wq;
  logic [AW-1:0]    raddr, waddr;
  logic             twe, wwe;
  logic [TimeW-1:0] twdata;
  logic [TimeW-1:0] t_lo, span;
  logic [WorkW-1:0] w_lo, work;
  logic             sel_hi;
  logic [CW-1:0]    first, last_i;
  logic [1:0]       mstep;
  logic [NumW-1:0]  prod;
  logic             dstart, dbusy, ddone;
  logic [NumW-1:0]  quo;
  logic             in_acc, cfg_wr;
  logic [63:0]      pp;

  assign in_acc = in_valid && in_ready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TARGET) ? target : 32'd0;
  assign in_ready = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TargetReset;
    end else if (cfg_wr && paddr == REG_TARGET) begin
      target <= pwdata;
    end
  end

  always_comb begin
    first = '0;
    last_i = len - CW'(1);
    if (int'(len) > Kept) begin
      first = CW'((int'(len) - Kept + 1) / 2);
      last_i = CW'((int'(len) - Kept + 1) / 2 + Kept - 1);
    end
  end

  always_comb begin
    raddr = '0;
    unique case (state)
      S_SORT_RD, S_SORT_WAIT: raddr = j_idx[AW-1:0] - AW'(1);
      S_SEL_RD, S_SEL_WAIT:   raddr = sel_hi ? last_i[AW-1:0] : first[AW-1:0];
      default:                raddr = i_idx[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    tq <= tmem[raddr];
    wq <= wmem[raddr];
    if (twe) tmem[waddr] <= twdata;
    if (wwe) wmem[waddr] <= {work_high, work_low};
  end

  always_comb begin
    twe = 1'b0;
    wwe = 1'b0;
    waddr = count[AW-1:0];
    twdata = sample_time;
    if (state == S_LOAD && in_acc && count < CW'(WINDOW)) begin
      twe = 1'b1;
      wwe = 1'b1;
    end else if (state == S_SORT_CMP && j_idx != '0 && tq > key) begin
      twe = 1'b1;
      waddr = j_idx[AW-1:0];
      twdata = tq;
    end else if (state == S_SORT_WR) begin
      twe = 1'b1;
      waddr = j_idx[AW-1:0];
      twdata = key;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:
        if (in_acc && last_sample) state_next = S_SORT_RD;
      S_SORT_RD:
        if (len <= CW'(1)) state_next = S_OUT;
        else if (i_idx >= len) state_next = S_SEL_RD;
        else if (j_idx == '0) state_next = S_SORT_WR;
        else state_next = S_SORT_WAIT;
      S_SORT_WAIT: state_next = S_SORT_CMP;
      S_SORT_CMP:  state_next = (tq > key) ? S_SORT_RD : S_SORT_WR;
      S_SORT_WR:   state_next = S_SORT_RD;
      S_SEL_RD:    state_next = S_SEL_WAIT;
      S_SEL_WAIT:  state_next = S_SEL_CAP;
      S_SEL_CAP:   state_next = sel_hi ? S_MUL : S_SEL_RD;
      S_MUL:       if (mstep == 2'd3) state_next = S_DIV;
      S_DIV:       if (ddone) state_next = S_OUT;
      S_OUT:       if (out_ready) state_next = S_LOAD;
      default:     state_next = S_LOAD;
    endcase
  end

  assign pp = 64'(work[32*mstep +: 32]) * 64'(target);
  assign dstart = (state == S_MUL) && (mstep == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD && in_acc) begin
        if (last_sample) begin
          count <= '0;
        end else if (count < CW'(WINDOW)) begin
          count <= count + CW'(1);
        end
      end
      if (state == S_OUT && out_ready) out_valid <= 1'b0;
      else if (state_next == S_OUT && state != S_OUT) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        len <= (count < CW'(WINDOW)) ? count + CW'(1) : count;
        i_idx <= CW'(1);
        j_idx <= CW'(1);
        sel_hi <= 1'b0;
        mstep <= '0;
        difficulty_low <= 64'd1;
        difficulty_high <= '0;
        overflowed <= 1'b0;
      end
      S_SORT_RD: if (j_idx == i_idx) key <= tmem[i_idx[AW-1:0]];
      S_SORT_CMP: if (tq > key) j_idx <= j_idx - CW'(1);
      S_SORT_WR: begin
        i_idx <= i_idx + CW'(1);
        j_idx <= i_idx + CW'(1);
      end
      S_SEL_CAP: begin
        if (!sel_hi) begin
          t_lo <= tq;
          w_lo <= wq;
          sel_hi <= 1'b1;
        end else begin
          span <= (tq == t_lo) ? 64'd1 : tq - t_lo;
          work <= wq - w_lo;
          prod <= NumW'(tq == t_lo ? 64'd0 : (tq - t_lo - 64'd1));
        end
      end
      S_MUL: begin
        prod <= prod + (NumW'(pp) << (32 * mstep));
        mstep <= mstep + 2'd1;
      end
      S_DIV: if (ddone) begin
        overflowed <= quo[NumW-1:WorkW] != '0;
        difficulty_low <= (quo[NumW-1:WorkW] != '0) ? 64'd0 : quo[63:0];
        difficulty_high <= (quo[NumW-1:WorkW] != '0) ? 64'd0 : quo[127:64];
      end
      default: ;
    endcase
  end

  wdr_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(prod + (NumW'(pp) << 96)),
    .divisor(span), .busy(dbusy), .done(ddone), .quotient(quo)
  );

  a_ready_only_load: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("accepting while result pending");
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    dbusy |-> state == S_DIV) else $error("divider busy outside divide");
  a_out_follows_done: assert property (@(posedge clk) disable iff (rst)
    ddone |=> out_valid) else $error("result not presented after divide");
endmodule

// ----- verif/wdr_checker.sv -----
// Checker: watches the sample and difficulty channels, predicts results, compares.
`timescale 1ns / 1ps
module wdr_checker
  import wdr_pkg::*;
#(
  parameter int unsigned WINDOW = 720,
  parameter int unsigned TRIM   = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] sample_time,
  input  logic [63:0] work_low,
  input  logic [63:0] work_high,
  input  logic        last_sample,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] difficulty_low,
  input  logic [63:0] difficulty_high,
  input  logic        overflowed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding
);
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        ovf;
  } diff_t;

  logic [63:0]  times [WINDOW];
  logic [127:0] works [WINDOW];
  int unsigned  count;
  logic [31:0]  target;
  diff_t        pending_diffs [$];

  assign outstanding = pending_diffs.size();

  function automatic diff_t retarget(int unsigned len);
    logic [63:0]  ordered [$];
    int           kept;
    int unsigned  first;
    int unsigned  stop;
    logic [63:0]  span;
    logic [127:0] work;
    logic [191:0] num;
    logic [191:0] quo;
    diff_t        d;
    d = '{lo: 64'd1, hi: 64'd0, ovf: 1'b0};
    if (len <= 1) return d;
    for (int i = 0; i < len; i++) ordered.push_back(times[i]);
    ordered.sort();
    kept = int'(WINDOW) - 2 * int'(TRIM);
    if (kept < 2) kept = 2;
    if (len <= kept) begin
      first = 0;
      stop = len;
    end else begin
      first = (len - kept + 1) / 2;
      stop = first + kept;
    end
    span = ordered[stop-1] - ordered[first];
    if (span == 64'd0) span = 64'd1;
    work = works[stop-1] - works[first];
    num = {64'd0, work} * {160'd0, target} + {128'd0, span - 64'd1};
    quo = num / {128'd0, span};
    if (quo[191:128] != 64'd0) d = '{lo: 64'd0, hi: 64'd0, ovf: 1'b1};
    else d = '{lo: quo[63:0], hi: quo[127:64], ovf: 1'b0};
    return d;
  endfunction

  task automatic report(string what, logic [127:0] got, logic [127:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    diff_t want;
    if (rst) begin
      count = 0;
      target = TargetReset;
      pending_diffs.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_TARGET) target = pwdata;
      if (in_valid && in_ready) begin
        if (count < WINDOW) begin
          times[count] = sample_time;
          works[count] = {work_high, work_low};
          count++;
        end
        if (last_sample) begin
          pending_diffs.push_back(retarget(count));
          count = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_diffs.size() == 0) begin
          report("unexpected word", {difficulty_high, difficulty_low}, 128'd0);
        end else begin
          want = pending_diffs.pop_front();
          if (difficulty_low !== want.lo) report("difficulty_low", difficulty_low, want.lo);
          if (difficulty_high !== want.hi) report("difficulty_high", difficulty_high, want.hi);
          if (overflowed !== want.ovf) report("overflowed", overflowed, want.ovf);
        end
      end
    end
  end
endmodule

// ----- verif/tb.sv -----
// Testbench top: drives sample windows and target writes, gives the verdict.
`timescale 1ns / 1ps
module tb
  import wdr_pkg::*;
();

  localparam int unsigned WINDOW = 720;
  localparam int unsigned TRIM   = 60;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] sample_time;
  logic [63:0] work_low;
  logic [63:0] work_high;
  logic        last_sample;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] difficulty_low;
  logic [63:0] difficulty_high;
  logic        overflowed;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          outstanding;
  int          tx_idle;
  int          rx_idle;
  int          words_sent;

  logic [63:0]  win_time [$];
  logic [127:0] win_work [$];

  window_difficulty_retarget #(.WINDOW(WINDOW), .TRIM(TRIM)) i_dut (.*);

  wdr_checker #(.WINDOW(WINDOW), .TRIM(TRIM)) i_checker (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  initial begin
    #60_000_000;
    $display("window_difficulty_retarget verification failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(logic [63:0] t, logic [127:0] w, logic last);
    while ($urandom_range(99) < tx_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_time = t;
    work_low = w[63:0];
    work_high = w[127:64];
    last_sample = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_window();
    for (int i = 0; i < win_time.size(); i++)
      send_word(win_time[i], win_work[i], i == win_time.size() - 1);
    win_time.delete();
    win_work.delete();
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_target(logic [31:0] value);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = REG_TARGET;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic add(logic [63:0] t, logic [127:0] w);
    win_time.push_back(t);
    win_work.push_back(w);
  endtask

  // sorted-ish timestamps with a few local swaps keep the sort short
  task automatic big_window(int unsigned len);
    logic [63:0]  t;
    logic [127:0] w;
    t = rand64() >> 2;
    w = {rand64() >> 4, rand64()};
    for (int i = 0; i < len; i++) begin
      t += $urandom_range(200, 1);
      w += {96'd0, $urandom};
      if (i > 0 && $urandom_range(19) == 0) add(win_time[i-1] - 64'd1, w);
      else add(t, w);
    end
    send_window();
  endtask

  task automatic random_window();
    int unsigned  len;
    int unsigned  mode;
    logic [63:0]  t;
    logic [127:0] w;
    len = ($urandom_range(9) == 0) ? 1 : $urandom_range(14, 2);
    mode = $urandom_range(3);
    t = rand64();
    w = {rand64(), rand64()};
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin
          t = rand64();
          w = {rand64(), rand64()};
        end
        1: begin
          t += $urandom_range(300);
          w += {64'd0, rand64() >> $urandom_range(63)};
        end
        2: w += {96'd0, $urandom};
        default: begin
          t = t - $urandom_range(1000) + $urandom_range(1000);
          w = {rand64() >> $urandom_range(64, 1), rand64()};
        end
      endcase
      add(t, w);
    end
    send_window();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sample_time = '0;
    work_low = '0;
    work_high = '0;
    last_sample = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REG_TARGET;
    pwdata = '0;
    words_sent = 0;
    tx_idle = 31;
    rx_idle = 61;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add(64'd0, 128'd0);
    send_window();
    add('1, '1);
    send_window();
    add(64'd500, 128'd0);
    add(64'd500, 128'd100);
    send_window();
    add('1, '1);
    add(64'd0, 128'd0);
    send_window();
    add(64'd10, 128'd7);
    add(64'd3, 128'd5);
    add(64'd99, 128'd900);
    send_window();
    write_target('1);
    add(64'd42, 128'd0);
    add(64'd42, '1);
    send_window();
    add(64'd0, 128'd0);
    add('1, 128'd1);
    send_window();
    write_target(32'd0);
    add(64'd1, 128'd3);
    add(64'd9, 128'd77);
    send_window();
    write_target(32'd1);
    big_window(WINDOW + 10);

    words_sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 31 : (phase == 1) ? 61 : 0;
      rx_idle = (phase == 0) ? 61 : (phase == 1) ? 31 : 0;
      write_target((phase == 1) ? 32'd120 : $urandom);
      while (words_sent < 90 * (phase + 1)) begin
        random_window();
        if ($urandom_range(24) == 0)
          write_target(($urandom_range(3) == 0) ? $urandom_range(3, 1) : $urandom);
      end
    end

    in_valid = 1'b0;
    for (int i = 0; i < 2_000_000 && outstanding != 0; i++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("window_difficulty_retarget verification clean");
    end else begin
      $display("window_difficulty_retarget verification failed");
    end
    $finish;
  end
endmodule
